@@ hdl/pba_pkg.sv @@
// Shared types, constants and helpers for the per-bin running average block.
// No dependencies; every other file imports this package.
package pba_pkg;

    localparam int SAMPLE_W = 24;              // sample and average width
    localparam int SUM_W    = SAMPLE_W + 10;   // per-bin running sum width
    localparam int LEN_W    = 11;              // frame_length / avg_length registers
    localparam int CNT_W    = 11;              // frame counter, also the divisor
    localparam int QUO_W    = SAMPLE_W - 1;    // quotient magnitude bits below saturation
    localparam int DIV_STEP = 4;               // quotient bits resolved per divider stage
    localparam int ENTRY_W  = SUM_W + SAMPLE_W;

    localparam int MAX_BINS_DEF  = 1024;
    localparam int MAX_FRAMES    = 1024;
    // avg_length is 11 bits wide, so a larger frame limit is clamped to 2047
    localparam int FRAMES_CLAMP  = (MAX_FRAMES < 2047) ? MAX_FRAMES : 2047;

    localparam logic [LEN_W-1:0] FRAME_LEN_RST = LEN_W'(1024);
    localparam logic [LEN_W-1:0] AVG_LEN_RST   = LEN_W'(16);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LENGTH   = CFG_IDX_W'(1);

    // input actions
    localparam logic ACT_FEED  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       frame_passed;
        logic                       last_in_frame;
    } out_beat_t;

    // per-beat frame bookkeeping from the controller
    typedef struct packed {
        logic             warmup;
        logic             last_in_frame;
        logic [CNT_W-1:0] count;
    } frame_info_t;

    // flags that ride along the divider
    typedef struct packed {
        logic frame_passed;
        logic last_in_frame;
    } div_tag_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ hdl/pba_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on pba_pkg for the address width helper.
module pba_ram
    import pba_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = MAX_BINS_DEF,
    localparam int AW   = addr_w(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pba_frame_ctrl.sv @@
// Configuration registers, bin position, frame counter, warm-up flag and clear sweep.
// Depends on pba_pkg.
module pba_frame_ctrl
    import pba_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int AW      = addr_w(MAX_BINS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    input  logic                 feed,
    input  logic                 clear,
    output logic [AW-1:0]        pos,
    output frame_info_t          info,
    output logic                 clearing,
    output logic [AW-1:0]        sweep_addr
);

    localparam int LW = ($clog2(MAX_BINS + 1) > LEN_W) ? $clog2(MAX_BINS + 1) : LEN_W;

    logic [LEN_W-1:0] frame_length_reg;
    logic [LEN_W-1:0] avg_length_reg;
    logic [AW-1:0]    bin_position_reg, bin_position_next;
    logic [CNT_W-1:0] frame_count_reg,  frame_count_next;
    logic             warmup_reg,       warmup_next;
    logic             clearing_reg;
    logic [AW-1:0]    sweep_addr_reg;

    logic [LW-1:0]    flen, flen_m1, bp_ext;
    logic [LEN_W-1:0] alen;
    logic             last, frame_start, start_warm;

    always_comb
    begin
        if (frame_length_reg == '0)
            flen = LW'(1);
        else if (LW'(frame_length_reg) > LW'(MAX_BINS))
            flen = LW'(MAX_BINS);
        else
            flen = LW'(frame_length_reg);

        if (avg_length_reg == '0)
            alen = LEN_W'(1);
        else if (avg_length_reg > LEN_W'(FRAMES_CLAMP))
            alen = LEN_W'(FRAMES_CLAMP);
        else
            alen = avg_length_reg;
    end

    assign flen_m1     = flen - LW'(1);
    assign bp_ext      = LW'(bin_position_reg);
    // a position at or past the last bin (frame length lowered) is the last bin
    assign last        = (bp_ext >= flen_m1);
    assign pos         = last ? flen_m1[AW-1:0] : bin_position_reg;
    assign frame_start = (bin_position_reg == '0);
    assign start_warm  = (frame_count_reg < CNT_W'(alen));

    always_comb
    begin
        frame_count_next = frame_count_reg;
        warmup_next      = warmup_reg;
        if (frame_start)
        begin
            warmup_next = start_warm;
            if (start_warm)
                frame_count_next = frame_count_reg + CNT_W'(1);
        end
        bin_position_next = last ? '0 : bin_position_reg + AW'(1);
    end

    assign info.warmup        = warmup_next;
    assign info.last_in_frame = last;
    assign info.count         = frame_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LEN_RST;
            avg_length_reg   <= AVG_LEN_RST;
            bin_position_reg <= '0;
            frame_count_reg  <= '0;
            warmup_reg       <= 1'b0;
            clearing_reg     <= 1'b1;
            sweep_addr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_FRAME_LENGTH)
                    frame_length_reg <= cfg_data;
                else if (cfg_index == CFG_AVG_LENGTH)
                    avg_length_reg <= cfg_data;
            end

            if (clear)
            begin
                bin_position_reg <= '0;
                frame_count_reg  <= '0;
                warmup_reg       <= 1'b0;
                clearing_reg     <= 1'b1;
                sweep_addr_reg   <= '0;
            end
            else
            begin
                if (feed)
                begin
                    bin_position_reg <= bin_position_next;
                    frame_count_reg  <= frame_count_next;
                    warmup_reg       <= warmup_next;
                end
                if (clearing_reg)
                begin
                    sweep_addr_reg <= sweep_addr_reg + AW'(1);
                    if (sweep_addr_reg == AW'(MAX_BINS - 1))
                        clearing_reg <= 1'b0;
                end
            end
        end
    end

    assign clearing   = clearing_reg;
    assign sweep_addr = sweep_addr_reg;

endmodule

@@ hdl/pba_divider.sv @@
// Pipelined signed divide of the running sum by the frame count, saturated to sample width.
// One prep stage, then DIV_STEP quotient bits per stage. Depends on pba_pkg.
module pba_divider
    import pba_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int AW      = addr_w(MAX_BINS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SUM_W-1:0]    in_sum,
    input  logic [CNT_W-1:0]           in_count,
    input  div_tag_t                   in_tag,
    input  logic [AW-1:0]              in_pos,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_avg,
    output logic signed [SUM_W-1:0]    out_sum,
    output div_tag_t                   out_tag,
    output logic [AW-1:0]              out_pos,
    input  logic [AW-1:0]              probe_pos,
    output logic                       probe_hit,
    output logic                       empty
);

    localparam int NST = (QUO_W + DIV_STEP - 1) / DIV_STEP;

    logic [NST:0]      v_reg;
    logic [NST:0]      adv;
    logic [NST:0]      hit;
    logic [CNT_W-1:0]  rem_reg  [NST+1];
    logic [QUO_W-1:0]  low_reg  [NST+1];
    logic [QUO_W-1:0]  quo_reg  [NST+1];
    logic [CNT_W-1:0]  den_reg  [NST+1];
    logic              neg_reg  [NST+1];
    logic              ovf_reg  [NST+1];
    logic              zero_reg [NST+1];
    logic [SUM_W-1:0]  sum_reg  [NST+1];
    div_tag_t          tag_reg  [NST+1];
    logic [AW-1:0]     pos_reg  [NST+1];

    // prep: magnitude, overflow test on the high bits, first partial remainder
    logic [SUM_W-1:0] mag;
    logic [CNT_W-1:0] mag_hi;
    assign mag    = in_sum[SUM_W-1] ? (~in_sum + SUM_W'(1)) : in_sum;
    assign mag_hi = mag[SUM_W-1:QUO_W];

    always_comb
    begin
        adv[NST] = !v_reg[NST] || out_ready;
        for (int k = NST - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
        for (int k = 0; k <= NST; k++)
            hit[k] = v_reg[k] && (pos_reg[k] == probe_pos);
    end

    assign in_ready  = adv[0];
    assign probe_hit = |hit;
    assign empty     = ~|v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k <= NST; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            rem_reg[0]  <= mag_hi;
            low_reg[0]  <= mag[QUO_W-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= in_count;
            neg_reg[0]  <= in_sum[SUM_W-1];
            ovf_reg[0]  <= (mag_hi >= in_count);
            zero_reg[0] <= (in_count == '0);
            sum_reg[0]  <= in_sum;
            tag_reg[0]  <= in_tag;
            pos_reg[0]  <= in_pos;
        end
    end

    for (genvar k = 1; k <= NST; k++)
    begin : g_stage
        logic [CNT_W-1:0] rem_c;
        logic [QUO_W-1:0] low_c;
        logic [QUO_W-1:0] quo_c;

        // restoring long division, one quotient bit per step
        always_comb
        begin
            logic [CNT_W:0] t;
            logic [CNT_W:0] diff;
            rem_c = rem_reg[k-1];
            low_c = low_reg[k-1];
            quo_c = quo_reg[k-1];
            for (int i = 0; i < DIV_STEP; i++)
            begin
                if ((k - 1) * DIV_STEP + i < QUO_W)
                begin
                    t     = {rem_c, low_c[QUO_W-1]};
                    low_c = low_c << 1;
                    diff  = t - {1'b0, den_reg[k-1]};
                    if (t >= {1'b0, den_reg[k-1]})
                    begin
                        rem_c = diff[CNT_W-1:0];
                        quo_c = {quo_c[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_c = t[CNT_W-1:0];
                        quo_c = {quo_c[QUO_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && v_reg[k-1])
            begin
                rem_reg[k]  <= rem_c;
                low_reg[k]  <= low_c;
                quo_reg[k]  <= quo_c;
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                sum_reg[k]  <= sum_reg[k-1];
                tag_reg[k]  <= tag_reg[k-1];
                pos_reg[k]  <= pos_reg[k-1];
            end
        end
    end

    localparam logic [SAMPLE_W-1:0] AVG_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] AVG_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic [SAMPLE_W-1:0] q_ext;
    assign q_ext = {1'b0, quo_reg[NST]};

    always_comb
    begin
        if (zero_reg[NST])
            out_avg = '0;
        else if (ovf_reg[NST])
            out_avg = neg_reg[NST] ? AVG_MIN : AVG_MAX;
        else
            out_avg = neg_reg[NST] ? (~q_ext + SAMPLE_W'(1)) : q_ext;
    end

    assign out_valid = v_reg[NST];
    assign out_sum   = sum_reg[NST];
    assign out_tag   = tag_reg[NST];
    assign out_pos   = pos_reg[NST];

endmodule

@@ hdl/per_bin_running_average.sv @@
// Per-bin running average: one beat per cycle sustained while the output is not stalled,
// set by the read-modify-write of the bin RAM. A bin reused while its previous beat is
// still in flight (frame length below 10 with the default sample width) waits for that
// write-back. Reset and each clear beat start a zeroing sweep of every bin RAM entry,
// during which no input beat is taken.
module per_bin_running_average
    import pba_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF,
    localparam int AW      = addr_w(MAX_BINS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    localparam int ACC_W = SUM_W + 2;
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Pipeline:
    //   accept : frame bookkeeping, RAM read issued at the bin's address
    //   S1     : read data back; new sum formed and saturated
    //   S2     : sum registered, handed to the divider
    //   divider: prep stage plus quotient stages
    //   out    : result register; the bin entry (sum, average) is written as it loads
    // Bar the clear sweep, entries are written only on entry to the output register, so
    // any beat in S1, S2 or the divider with the same bin blocks a new read of that bin.

    logic              feed, clear;
    logic [AW-1:0]     pos;
    frame_info_t       info;
    logic              clearing;
    logic [AW-1:0]     sweep_addr;

    logic [ENTRY_W-1:0] rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    // S1
    logic                       s1_valid_reg;
    logic [AW-1:0]              s1_pos_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    frame_info_t                s1_info_reg;
    logic                       s1_adv;

    // S2
    logic                       s2_valid_reg;
    logic [AW-1:0]              s2_pos_reg;
    logic signed [SUM_W-1:0]    s2_sum_reg;
    logic [CNT_W-1:0]           s2_count_reg;
    div_tag_t                   s2_tag_reg;
    logic                       s2_adv;

    // divider
    logic                       div_in_ready;
    logic                       div_out_valid;
    logic                       div_out_ready;
    logic signed [SAMPLE_W-1:0] div_avg;
    logic signed [SUM_W-1:0]    div_sum;
    div_tag_t                   div_tag;
    logic [AW-1:0]              div_pos;
    logic                       div_hit;
    logic                       div_empty;

    // output
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic      out_take;
    logic      write_back;

    logic hazard, pipe_empty;
    logic [SUM_W-1:0]    old_sum;
    logic [SAMPLE_W-1:0] old_avg;
    logic [ACC_W-1:0]    acc;
    logic [SUM_W-1:0]    new_sum;
    logic                acc_ovf;

    assign cfg_ready = 1'b1;

    pba_frame_ctrl #(
        .MAX_BINS (MAX_BINS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .feed       (feed),
        .clear      (clear),
        .pos        (pos),
        .info       (info),
        .clearing   (clearing),
        .sweep_addr (sweep_addr)
    );

    // --- input handshake -------------------------------------------------
    assign hazard = (s1_valid_reg && (s1_pos_reg == pos))
                 || (s2_valid_reg && (s2_pos_reg == pos))
                 || div_hit;
    // a clear waits until every in-flight beat has written its bin
    assign pipe_empty = !s1_valid_reg && !s2_valid_reg && div_empty;

    always_comb
    begin
        if (clearing)
            in_ready = 1'b0;
        else if (in_data.action == ACT_CLEAR)
            in_ready = pipe_empty;
        else
            in_ready = s1_adv && !hazard;
    end

    assign feed  = in_valid && in_ready && (in_data.action == ACT_FEED);
    assign clear = in_valid && in_ready && (in_data.action == ACT_CLEAR);

    // --- bin RAM: {sum, average} per bin ---------------------------------
    assign write_back = div_out_valid && out_take;
    assign ram_we     = clearing || write_back;
    assign ram_waddr  = clearing ? sweep_addr : div_pos;
    assign ram_wdata  = clearing ? '0 : {div_sum, div_avg};

    pba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (feed),
        .raddr (pos),
        .rdata (rdata)
    );

    // --- S1: new running sum --------------------------------------------
    assign s2_adv = !s2_valid_reg || div_in_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;

    assign old_sum = rdata[ENTRY_W-1:SAMPLE_W];
    assign old_avg = rdata[SAMPLE_W-1:0];

    // warm-up adds the sample; afterwards the old average is swapped for it
    always_comb
    begin
        acc = {{2{old_sum[SUM_W-1]}}, old_sum}
            + {{(ACC_W-SAMPLE_W){s1_x_reg[SAMPLE_W-1]}}, s1_x_reg};
        if (!s1_info_reg.warmup)
            acc = acc - {{(ACC_W-SAMPLE_W){old_avg[SAMPLE_W-1]}}, old_avg};
        acc_ovf = (acc[ACC_W-1:SUM_W-1] != '0) && (acc[ACC_W-1:SUM_W-1] != '1);
        if (acc_ovf)
            new_sum = acc[ACC_W-1] ? SUM_MIN : SUM_MAX;
        else
            new_sum = acc[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= feed;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed)
        begin
            s1_pos_reg  <= pos;
            s1_x_reg    <= in_data.sample;
            s1_info_reg <= info;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_pos_reg                <= s1_pos_reg;
            s2_sum_reg                <= new_sum;
            s2_count_reg              <= s1_info_reg.count;
            s2_tag_reg.frame_passed   <= !s1_info_reg.warmup;
            s2_tag_reg.last_in_frame  <= s1_info_reg.last_in_frame;
        end
    end

    // --- divider ---------------------------------------------------------
    pba_divider #(
        .MAX_BINS (MAX_BINS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_ready  (div_in_ready),
        .in_sum    (s2_sum_reg),
        .in_count  (s2_count_reg),
        .in_tag    (s2_tag_reg),
        .in_pos    (s2_pos_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_avg   (div_avg),
        .out_sum   (div_sum),
        .out_tag   (div_tag),
        .out_pos   (div_pos),
        .probe_pos (pos),
        .probe_hit (div_hit),
        .empty     (div_empty)
    );

    // --- output register ------------------------------------------------
    assign out_take      = !out_valid_reg || out_ready;
    assign div_out_ready = out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_back)
        begin
            out_data_reg.average       <= div_avg;
            out_data_reg.frame_passed  <= div_tag.frame_passed;
            out_data_reg.last_in_frame <= div_tag.last_in_frame;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
